// ----- sv/its_pkg.sv -----
package its_pkg;

  localparam int unsigned FracDigitsDef = 9;
  localparam int unsigned FracW         = 30;
  localparam int unsigned AccW          = 47;
  localparam int unsigned OpW           = 30;
  localparam int unsigned DaysW         = 23;

  // positions within the pattern
  localparam logic [4:0] PosDash0     = 5'd4;
  localparam logic [4:0] PosDash1     = 5'd7;
  localparam logic [4:0] PosTee       = 5'd10;
  localparam logic [4:0] PosColon0    = 5'd13;
  localparam logic [4:0] PosColon1    = 5'd16;
  localparam logic [4:0] PosYearLo    = 5'd2;
  localparam logic [4:0] PosYearEnd   = 5'd3;
  localparam logic [4:0] PosMonthEnd  = 5'd6;
  localparam logic [4:0] PosDayEnd    = 5'd9;
  localparam logic [4:0] PosHourEnd   = 5'd12;
  localparam logic [4:0] PosMinuteEnd = 5'd15;
  localparam logic [4:0] PosLastFixed = 5'd18;
  localparam logic [4:0] PosDotOrZ    = 5'd19;
  localparam logic [4:0] PosFracFirst = 5'd20;
  localparam logic [4:0] PosFracMore  = 5'd21;
  localparam logic [4:0] PosDone      = 5'd22;

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChTee   = 8'h54;
  localparam logic [7:0] ChZed   = 8'h5A;
  localparam logic [7:0] ChDot   = 8'h2E;

  // 146097 + 719468 + 1, year offset by 400 and day counted from 1
  localparam logic [DaysW-1:0] DaysOffset = 23'd865566;
  localparam logic [OpW-1:0]   DaysPerCent = 30'd36524;
  localparam logic [OpW-1:0]   DaysPerYear = 30'd365;
  localparam logic [OpW-1:0]   SecPerHour  = 30'd3600;
  localparam logic [OpW-1:0]   SecPerMin   = 30'd60;
  localparam logic [OpW-1:0]   NanoPerSec  = 30'd1000000000;
  localparam logic [OpW-1:0]   OpOne       = 30'd1;

  typedef enum logic [2:0] {
    StOk,
    StFormat,
    StDate,
    StHour,
    StMinute,
    StSecond,
    StLeapPos
  } its_status_e;

  typedef enum logic [3:0] {
    SIdle,
    SCheck,
    SDays0,
    SDays1,
    SDays2,
    SNanos0,
    SNanos1,
    SNanos2,
    SNanos3,
    SNanos4,
    SOut
  } its_state_e;

  typedef struct packed {
    logic             fmt_ok;
    logic [6:0]       cent;
    logic [6:0]       ylo;
    logic [6:0]       month;
    logic [6:0]       day;
    logic [6:0]       hour;
    logic [6:0]       minute;
    logic [6:0]       second;
    logic [FracW-1:0] frac;
    logic [3:0]       frac_cnt;
  } its_fields_t;

  typedef struct packed {
    logic           en;
    logic           use_acc;
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
  } its_mac_op_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c[7:4] == 4'h3) && (c[3:0] <= 4'd9);
  endfunction

  function automatic logic [6:0] mul10_add7(input logic [6:0] acc, input logic [3:0] d);
    return {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, d};
  endfunction

  function automatic logic [FracW-1:0] mul10_add_frac(input logic [FracW-1:0] acc,
                                                      input logic [3:0] d);
    return {acc[FracW-4:0], 3'b000} + {acc[FracW-2:0], 1'b0} + {{(FracW-4){1'b0}}, d};
  endfunction

  function automatic logic [6:0] month_len(input logic [6:0] m, input logic leap);
    logic [6:0] len;
    case (m)
      7'd2:                      len = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   len = 7'd30;
      default:                   len = 7'd31;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] doy_of_month(input logic [6:0] m);
    logic [8:0] v;
    case (m)
      7'd1:    v = 9'd306;
      7'd2:    v = 9'd337;
      7'd4:    v = 9'd31;
      7'd5:    v = 9'd61;
      7'd6:    v = 9'd92;
      7'd7:    v = 9'd122;
      7'd8:    v = 9'd153;
      7'd9:    v = 9'd184;
      7'd10:   v = 9'd214;
      7'd11:   v = 9'd245;
      7'd12:   v = 9'd275;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // scale for padding the kept fraction digits to nanoseconds
  function automatic logic [OpW-1:0] pow10_pad(input logic [3:0] cnt);
    logic [OpW-1:0] v;
    case (cnt)
      4'd0:    v = 30'd1000000000;
      4'd1:    v = 30'd100000000;
      4'd2:    v = 30'd10000000;
      4'd3:    v = 30'd1000000;
      4'd4:    v = 30'd100000;
      4'd5:    v = 30'd10000;
      4'd6:    v = 30'd1000;
      4'd7:    v = 30'd100;
      4'd8:    v = 30'd10;
      default: v = 30'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/its_char_if.sv -----
interface its_char_if;
  import its_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- sv/its_res_if.sv -----
interface its_res_if;
  import its_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic signed [DaysW-1:0] epoch_days;
  logic [AccW-1:0]         nanos_of_day;
  logic                    leap_second;

  modport source (output valid, output status, output epoch_days, output nanos_of_day,
                  output leap_second, input ready);
  modport sink (input valid, input status, input epoch_days, input nanos_of_day,
                input leap_second, output ready);
endinterface

// ----- sv/its_parser.sv -----
module its_parser #(
  parameter int unsigned FRACTION_DIGITS = its_pkg::FracDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          char_code_i,
  input  logic                clr_i,
  output its_pkg::its_fields_t fields_o
);
  import its_pkg::*;

  logic [4:0]       pos_q, pos_d;
  logic             err_q, err_d;
  logic [6:0]       cent_q, cent_d, ylo_q, ylo_d, month_q, month_d, day_q, day_d;
  logic [6:0]       hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             dig;
  logic             ok;
  logic [3:0]       d;

  assign dig = is_digit(char_code_i);
  assign d   = char_code_i[3:0];

  always_comb begin
    pos_d    = pos_q;
    err_d    = err_q;
    cent_d   = cent_q;
    ylo_d    = ylo_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    ok       = 1'b1;
    if (clr_i) begin
      pos_d    = '0;
      err_d    = 1'b0;
      cent_d   = '0;
      ylo_d    = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      frac_d   = '0;
      cnt_d    = '0;
    end else if (take_i && !err_q) begin
      if (pos_q <= PosLastFixed) begin
        if (pos_q == PosDash0 || pos_q == PosDash1) begin
          ok = (char_code_i == ChDash);
        end else if (pos_q == PosTee) begin
          ok = (char_code_i == ChTee);
        end else if (pos_q == PosColon0 || pos_q == PosColon1) begin
          ok = (char_code_i == ChColon);
        end else if (!dig) begin
          ok = 1'b0;
        end else if (pos_q < PosYearLo) begin
          cent_d = mul10_add7(cent_q, d);
        end else if (pos_q <= PosYearEnd) begin
          ylo_d = mul10_add7(ylo_q, d);
        end else if (pos_q <= PosMonthEnd) begin
          month_d = mul10_add7(month_q, d);
        end else if (pos_q <= PosDayEnd) begin
          day_d = mul10_add7(day_q, d);
        end else if (pos_q <= PosHourEnd) begin
          hour_d = mul10_add7(hour_q, d);
        end else if (pos_q <= PosMinuteEnd) begin
          minute_d = mul10_add7(minute_q, d);
        end else begin
          second_d = mul10_add7(second_q, d);
        end
        pos_d = pos_q + 5'd1;
      end else if (pos_q == PosDotOrZ) begin
        if (char_code_i == ChDot) begin
          pos_d = PosFracFirst;
        end else if (char_code_i == ChZed) begin
          pos_d = PosDone;
        end else begin
          ok = 1'b0;
        end
      end else if (pos_q == PosFracFirst || pos_q == PosFracMore) begin
        if (dig) begin
          // digits past the kept count are only checked
          if (cnt_q < 4'(FRACTION_DIGITS)) begin
            frac_d = mul10_add_frac(frac_q, d);
            cnt_d  = cnt_q + 4'd1;
          end
          pos_d = PosFracMore;
        end else if (pos_q == PosFracMore && char_code_i == ChZed) begin
          pos_d = PosDone;
        end else begin
          ok = 1'b0;
        end
      end else begin
        ok = 1'b0;
      end
      if (!ok) begin
        err_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= 1'b0;
      cent_q   <= '0;
      ylo_q    <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      cnt_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      err_q    <= err_d;
      cent_q   <= cent_d;
      ylo_q    <= ylo_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      cnt_q    <= cnt_d;
    end
  end

  always_comb begin
    fields_o.fmt_ok   = !err_q && (pos_q == PosDone);
    fields_o.cent     = cent_q;
    fields_o.ylo      = ylo_q;
    fields_o.month    = month_q;
    fields_o.day      = day_q;
    fields_o.hour     = hour_q;
    fields_o.minute   = minute_q;
    fields_o.second   = second_q;
    fields_o.frac     = frac_q;
    fields_o.frac_cnt = cnt_q;
  end

endmodule

// ----- sv/its_mac.sv -----
module its_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  its_pkg::its_mac_op_t        op_i,
  output logic [its_pkg::AccW-1:0]    acc_o
);
  import its_pkg::*;

  logic [AccW-1:0]  acc_q, acc_d;
  logic [2*OpW-1:0] prod;

  assign prod = op_i.a * op_i.b;

  always_comb begin
    acc_d = acc_q;
    if (op_i.en) begin
      acc_d = (op_i.use_acc ? acc_q : '0) + prod[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- sv/its_seq.sv -----
module its_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  its_pkg::its_fields_t          fields_i,
  output logic                          clr_o,
  output its_pkg::its_mac_op_t          mac_op_o,
  input  logic [its_pkg::AccW-1:0]      mac_acc_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [2:0]                    status_o,
  output logic signed [its_pkg::DaysW-1:0] epoch_days_o,
  output logic [its_pkg::AccW-1:0]      nanos_o,
  output logic                          leap_o
);
  import its_pkg::*;

  its_state_e              state_q, state_d;
  its_status_e             stat_q, stat_d;
  logic [6:0]              c_adj_q, c_adj_d, l_adj_q, l_adj_d;
  logic                    leap_q, leap_d;
  logic [DaysW-1:0]        days_q, days_d;
  logic                    out_valid_q, out_valid_d;
  its_status_e             out_stat_q, out_stat_d;
  logic signed [DaysW-1:0] out_days_q, out_days_d;
  logic [AccW-1:0]         out_nanos_q, out_nanos_d;
  logic                    out_leap_q, out_leap_d;

  logic       leap_year;
  logic [6:0] mlen;
  logic       early;
  logic [6:0] sec_adj;
  logic [8:0] day_sum;
  logic       load;
  logic       in_take;

  assign in_take = in_valid_i && in_ready_o;

  // y % 4 only sees the low two digits; a century year needs century % 4
  assign leap_year = (fields_i.ylo[1:0] == 2'b00) &&
                     ((fields_i.ylo != 7'd0) || (fields_i.cent[1:0] == 2'b00));
  assign mlen      = month_len(fields_i.month, leap_year);
  assign early     = (fields_i.month <= 7'd2);
  assign sec_adj   = (fields_i.second == 7'd60) ? 7'd59 : fields_i.second;
  assign day_sum   = 9'(c_adj_q[6:2]) + 9'(l_adj_q[6:2]) +
                     doy_of_month(fields_i.month) + 9'(fields_i.day);
  assign load      = (state_q == SOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    stat_d       = stat_q;
    c_adj_d      = c_adj_q;
    l_adj_d      = l_adj_q;
    leap_d       = leap_q;
    days_d       = days_q;
    in_ready_o   = 1'b0;
    clr_o        = 1'b0;
    mac_op_o     = '0;
    mac_op_o.use_acc = 1'b1;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_last_i) begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (!fields_i.fmt_ok) begin
          stat_d = StFormat;
        end else if (fields_i.month < 7'd1 || fields_i.month > 7'd12 ||
                     fields_i.day < 7'd1 || fields_i.day > mlen) begin
          stat_d = StDate;
        end else if (fields_i.hour > 7'd23) begin
          stat_d = StHour;
        end else if (fields_i.minute > 7'd59) begin
          stat_d = StMinute;
        end else if (fields_i.second > 7'd60) begin
          stat_d = StSecond;
        end else if (fields_i.second == 7'd60 &&
                     !(fields_i.hour == 7'd23 && fields_i.minute == 7'd59)) begin
          stat_d = StLeapPos;
        end else begin
          stat_d = StOk;
        end
        leap_d = (fields_i.second == 7'd60);
        // march-based year, offset by four centuries to stay positive
        if (early && fields_i.ylo == 7'd0) begin
          c_adj_d = fields_i.cent + 7'd3;
          l_adj_d = 7'd99;
        end else if (early) begin
          c_adj_d = fields_i.cent + 7'd4;
          l_adj_d = fields_i.ylo - 7'd1;
        end else begin
          c_adj_d = fields_i.cent + 7'd4;
          l_adj_d = fields_i.ylo;
        end
        state_d = (stat_d == StOk) ? SDays0 : SOut;
      end
      SDays0: begin
        mac_op_o.en      = 1'b1;
        mac_op_o.use_acc = 1'b0;
        mac_op_o.a       = OpW'(c_adj_q);
        mac_op_o.b       = DaysPerCent;
        state_d          = SDays1;
      end
      SDays1: begin
        mac_op_o.en = 1'b1;
        mac_op_o.a  = OpW'(l_adj_q);
        mac_op_o.b  = DaysPerYear;
        state_d     = SDays2;
      end
      SDays2: begin
        mac_op_o.en = 1'b1;
        mac_op_o.a  = OpW'(day_sum);
        mac_op_o.b  = OpOne;
        state_d     = SNanos0;
      end
      SNanos0: begin
        days_d           = mac_acc_i[DaysW-1:0] - DaysOffset;
        mac_op_o.en      = 1'b1;
        mac_op_o.use_acc = 1'b0;
        mac_op_o.a       = OpW'(fields_i.hour);
        mac_op_o.b       = SecPerHour;
        state_d          = SNanos1;
      end
      SNanos1: begin
        mac_op_o.en = 1'b1;
        mac_op_o.a  = OpW'(fields_i.minute);
        mac_op_o.b  = SecPerMin;
        state_d     = SNanos2;
      end
      SNanos2: begin
        mac_op_o.en = 1'b1;
        mac_op_o.a  = OpW'(sec_adj);
        mac_op_o.b  = OpOne;
        state_d     = SNanos3;
      end
      SNanos3: begin
        mac_op_o.en      = 1'b1;
        mac_op_o.use_acc = 1'b0;
        mac_op_o.a       = OpW'(mac_acc_i[16:0]);
        mac_op_o.b       = NanoPerSec;
        state_d          = SNanos4;
      end
      SNanos4: begin
        mac_op_o.en = 1'b1;
        mac_op_o.a  = fields_i.frac;
        mac_op_o.b  = pow10_pad(fields_i.frac_cnt);
        state_d     = SOut;
      end
      SOut: begin
        if (load) begin
          clr_o   = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_days_d  = out_days_q;
    out_nanos_d = out_nanos_q;
    out_leap_d  = out_leap_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_stat_d  = stat_q;
      out_days_d  = (stat_q == StOk) ? $signed(days_q) : '0;
      out_nanos_d = (stat_q == StOk) ? mac_acc_i : '0;
      out_leap_d  = (stat_q == StOk) && leap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q      <= stat_d;
    c_adj_q     <= c_adj_d;
    l_adj_q     <= l_adj_d;
    leap_q      <= leap_d;
    days_q      <= days_d;
    out_stat_q  <= out_stat_d;
    out_days_q  <= out_days_d;
    out_nanos_q <= out_nanos_d;
    out_leap_q  <= out_leap_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign epoch_days_o = out_days_q;
  assign nanos_o      = out_nanos_q;
  assign leap_o       = out_leap_q;

  a_last_starts_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_last_i) |=> (state_q == SCheck))
    else $error("last item did not start the check");

  a_error_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q != StOk) |->
      (out_days_q == '0 && out_nanos_q == '0 && !out_leap_q))
    else $error("error result carries a nonzero payload");

  a_leap_at_day_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_leap_q) |->
      (out_stat_q == StOk && out_nanos_q >= 47'd86399000000000))
    else $error("leap second outside the last second of the day");

  a_days_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q == StOk) |->
      (out_days_q >= -23'sd719528 && out_days_q <= 23'sd2932896))
    else $error("day count out of range");

  a_nanos_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_nanos_q <= 47'd86399999999999))
    else $error("nanoseconds past the end of the day");

endmodule

// ----- sv/iso8601_utc_timestamp_parser.sv -----
// channel   dir  handshake       payload
// char_in   in   valid / ready   char_code[7:0], last_char
// res_out   out  valid / ready   status[2:0], epoch_days[22:0] signed,
//                                nanos_of_day[46:0], leap_second
//
// a character without the last flag takes one cycle; they stream back to back
// the last character starts the sequencer: a check state, eight steps of the
// shared multiply-accumulate unit for a good stamp and none for an error, and a
// load state, during which char_in.ready is low
// the load waits while the previous result still sits in the output register
// rst_ni clears the parser, sequencer and output valid asynchronously
module iso8601_utc_timestamp_parser #(
  parameter int unsigned FRACTION_DIGITS = its_pkg::FracDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  its_char_if.sink   char_in,
  its_res_if.source  res_out
);
  import its_pkg::*;

  its_fields_t     fields;
  its_mac_op_t     mac_op;
  logic [AccW-1:0] mac_acc;
  logic            clr;
  logic            in_ready;
  logic            take;

  assign char_in.ready = in_ready;
  assign take          = char_in.valid && in_ready;

  its_parser #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_in.char_code),
    .clr_i       (clr),
    .fields_o    (fields)
  );

  its_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (mac_acc)
  );

  its_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (char_in.valid),
    .in_last_i    (char_in.last_char),
    .in_ready_o   (in_ready),
    .fields_i     (fields),
    .clr_o        (clr),
    .mac_op_o     (mac_op),
    .mac_acc_i    (mac_acc),
    .out_ready_i  (res_out.ready),
    .out_valid_o  (res_out.valid),
    .status_o     (res_out.status),
    .epoch_days_o (res_out.epoch_days),
    .nanos_o      (res_out.nanos_of_day),
    .leap_o       (res_out.leap_second)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import its_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracKeep = FracDigitsDef;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam int TargetChars = 1850;
  localparam int PrintCap = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       hold;
  } char_item_t;

  typedef struct packed {
    its_status_e             status;
    logic signed [DaysW-1:0] days;
    logic [AccW-1:0]         nanos;
    logic                    leap;
  } stamp_t;

  logic clk_i;
  logic rst_ni;

  its_char_if char_bus ();
  its_res_if  res_bus ();

  iso8601_utc_timestamp_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_in (char_bus),
    .res_out (res_bus)
  );

  char_item_t pending[$];
  char_item_t next_item;
  stamp_t     expected_stamps[$];
  stamp_t     want;
  logic [7:0] staged[$];

  // parser state mirrored from the block
  logic [4:0]  p_pos;
  bit          p_err;
  int unsigned yr_acc, mo_acc, dy_acc, hr_acc, mi_acc, se_acc, fr_acc, fr_cnt;

  int errors;
  int chars_taken;
  int strings_done;
  int results_seen;
  int status_tally[8];

  int gap_left;
  int burst_left;
  logic [15:0] rdy_pat;
  logic [3:0]  rdy_idx;
  int          rdy_cycles;

  string fixed_cases[$] = {
    "1970-01-01T00:00:00Z",
    "0000-01-01T00:00:00Z",
    "9999-12-31T23:59:59.999999999Z",
    "2016-12-31T23:59:60.5Z",
    "2016-12-31T12:59:60Z",
    "2000-02-29T01:02:03.1234567891234Z",
    "1900-02-29T00:00:00Z",
    "2023-04-31T00:00:00Z",
    "2023-00-10T00:00:00Z",
    "2023-13-10T00:00:00Z",
    "2023-05-00T99:99:99Z",
    "2023-05-01T24:00:00Z",
    "2023-05-01T23:60:00Z",
    "2023-05-01T23:59:61Z",
    "2023-05-01T23:59:99.0Z",
    "2023-05-01T23:59:59",
    "2023-05-01T23:59:59.Z",
    "2023-05-01T23:59:59ZZ",
    "2023/05-01T00:00:00Z",
    "2023-05-01t00:00:00Z",
    "2023-05-01T00:00:00z",
    "2023-0:-01T00:00:00Z",
    "2023-0/-01T00:00:00Z",
    "Z"
  };

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      2:              return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic int unsigned days_before_month(input int unsigned m);
    case (m)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  // days from 0000-01-01 to the first of year y, year zero being a leap year
  function automatic longint days_before_year(input int unsigned y);
    return longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic void clear_parser();
    p_pos  = '0;
    p_err  = 1'b0;
    yr_acc = 0;
    mo_acc = 0;
    dy_acc = 0;
    hr_acc = 0;
    mi_acc = 0;
    se_acc = 0;
    fr_acc = 0;
    fr_cnt = 0;
  endfunction

  function automatic bit take_char(input logic [7:0] ch);
    int unsigned dv;
    bit num;
    num = (ch >= ChZero) && (ch <= ChNine);
    dv  = int'(ch) - int'(ChZero);
    if (p_pos <= PosLastFixed) begin
      if (p_pos == PosDash0 || p_pos == PosDash1) begin
        if (ch != ChDash) return 1'b0;
      end else if (p_pos == PosTee) begin
        if (ch != ChTee) return 1'b0;
      end else if (p_pos == PosColon0 || p_pos == PosColon1) begin
        if (ch != ChColon) return 1'b0;
      end else begin
        if (!num) return 1'b0;
        if (p_pos <= PosYearEnd) yr_acc = (yr_acc * 10 + dv) % 16384;
        else if (p_pos <= PosMonthEnd) mo_acc = (mo_acc * 10 + dv) % 128;
        else if (p_pos <= PosDayEnd) dy_acc = (dy_acc * 10 + dv) % 128;
        else if (p_pos <= PosHourEnd) hr_acc = (hr_acc * 10 + dv) % 128;
        else if (p_pos <= PosMinuteEnd) mi_acc = (mi_acc * 10 + dv) % 128;
        else se_acc = (se_acc * 10 + dv) % 128;
      end
      p_pos = p_pos + 5'd1;
      return 1'b1;
    end
    if (p_pos == PosDotOrZ) begin
      if (ch == ChDot) begin
        p_pos = PosFracFirst;
        return 1'b1;
      end
      if (ch == ChZed) begin
        p_pos = PosDone;
        return 1'b1;
      end
      return 1'b0;
    end
    if (p_pos == PosFracFirst || p_pos == PosFracMore) begin
      if (num) begin
        // digits past the kept count are checked but dropped
        if (fr_cnt < FracKeep) begin
          fr_acc = (fr_acc * 10 + dv) % (1 << 30);
          fr_cnt++;
        end
        p_pos = PosFracMore;
        return 1'b1;
      end
      if (p_pos == PosFracMore && ch == ChZed) begin
        p_pos = PosDone;
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic parse_char(input logic [7:0] ch, input logic fin);
    stamp_t r;
    longint unsigned pad;
    longint unsigned secs;
    longint days;
    if (!p_err && !take_char(ch)) p_err = 1'b1;
    if (fin) begin
      r.status = StOk;
      r.days   = '0;
      r.nanos  = '0;
      r.leap   = 1'b0;
      if (p_err || p_pos != PosDone) r.status = StFormat;
      else if (mo_acc < 1 || mo_acc > 12 || dy_acc < 1 || dy_acc > month_days(yr_acc, mo_acc))
        r.status = StDate;
      else if (hr_acc > 23) r.status = StHour;
      else if (mi_acc > 59) r.status = StMinute;
      else if (se_acc > 60) r.status = StSecond;
      else if (se_acc == 60 && !(hr_acc == 23 && mi_acc == 59)) r.status = StLeapPos;
      else begin
        pad = fr_acc;
        for (int k = fr_cnt; k < 9; k++) pad = pad * 10;
        secs = longint'(hr_acc) * 3600 + mi_acc * 60 + ((se_acc == 60) ? 59 : se_acc);
        days = days_before_year(yr_acc) + days_before_month(mo_acc) + dy_acc - 1
               - days_before_year(1970);
        if (mo_acc > 2 && is_leap(yr_acc)) days = days + 1;
        r.days  = DaysW'(days);
        r.nanos = AccW'(secs * 64'd1000000000 + pad);
        r.leap  = (se_acc == 60);
      end
      expected_stamps.push_back(r);
      status_tally[r.status]++;
      strings_done++;
      clear_parser();
    end
  endtask

  task automatic report(input string what);
    errors++;
    if (errors <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic stage_text(input string s);
    for (int i = 0; i < s.len(); i++) staged.push_back(s[i]);
  endtask

  task automatic commit(input bit hold);
    char_item_t it;
    for (int i = 0; i < staged.size(); i++) begin
      it.ch   = staged[i];
      it.last = (i == staged.size() - 1);
      it.hold = hold && (i == 0);
      pending.push_back(it);
    end
    staged.delete();
  endtask

  task automatic stage_stamp(input int unsigned y, mo, dy, hh, mm, ss, nf);
    stage_text($sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, dy, hh, mm, ss));
    if (nf > 0) begin
      staged.push_back(ChDot);
      for (int i = 0; i < nf; i++) staged.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    staged.push_back(ChZed);
  endtask

  task automatic stage_rand_stamp(input bit edgy);
    int unsigned y, mo, dy, hh, mm, ss, nf;
    y  = $urandom_range(0, 9999);
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    if (mo >= 1 && mo <= 12 && $urandom_range(0, 6) != 0)
      dy = $urandom_range(1, month_days(y, mo));
    else
      dy = $urandom_range(0, 99);
    hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    case ($urandom_range(0, 19))
      0:       ss = 60;
      1:       ss = $urandom_range(61, 99);
      2: begin
        hh = 23;
        mm = 59;
        ss = 60;
      end
      default: ss = $urandom_range(0, 59);
    endcase
    if (edgy) begin
      // month ends, february in all kinds of years, the leap second slot
      case ($urandom_range(0, 2))
        0: begin
          mo = 2;
          dy = $urandom_range(28, 30);
          y  = $urandom_range(0, 24) * 400 + $urandom_range(0, 3) * 100 + $urandom_range(0, 3);
        end
        1: begin
          mo = $urandom_range(1, 12);
          dy = month_days(y, mo) + $urandom_range(0, 1);
        end
        default: begin
          hh = 23;
          mm = 59;
          ss = $urandom_range(59, 61);
        end
      endcase
    end
    nf = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    stage_stamp(y, mo, dy, hh, mm, ss, nf);
  endtask

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    char_bus.valid = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    res_bus.ready = 1'b0;
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender: bursts of items separated by gaps, with an occasional hold until drained
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_bus.valid && char_bus.ready) begin
        parse_char(char_bus.char_code, char_bus.last_char);
        chars_taken++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          char_bus.valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].hold && expected_stamps.size() != 0)) begin
          next_item = pending.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= next_item.ch;
          char_bus.last_char <= next_item.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a rotating pattern that changes now and then
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (expected_stamps.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_stamps.pop_front();
          if (res_bus.status !== want.status)
            report($sformatf("status got %0d want %0d", res_bus.status, want.status));
          if (res_bus.epoch_days !== want.days)
            report($sformatf("epoch_days got %0d want %0d", res_bus.epoch_days, want.days));
          if (res_bus.nanos_of_day !== want.nanos)
            report($sformatf("nanos_of_day got %0d want %0d", res_bus.nanos_of_day,
                             want.nanos));
          if (res_bus.leap_second !== want.leap)
            report($sformatf("leap_second got %0b want %0b", res_bus.leap_second, want.leap));
        end
      end
      rdy_cycles++;
      if (rdy_cycles >= 300) begin
        rdy_cycles = 0;
        case ($urandom_range(0, 3))
          0:       rdy_pat = 16'hFFFF;
          1:       rdy_pat = 16'($urandom()) | 16'h0001;
          2:       rdy_pat = 16'h5555;
          default: rdy_pat = 16'h0001;
        endcase
      end
      rdy_idx = rdy_idx + 4'd1;
      res_bus.ready <= rdy_pat[rdy_idx];
    end
  end

  initial begin
    int target;
    int kind;
    int cut;
    rdy_pat    = 16'hFFFF;
    rdy_idx    = '0;
    rdy_cycles = 0;
    gap_left   = 0;
    burst_left = 0;

    foreach (fixed_cases[i]) begin
      stage_text(fixed_cases[i]);
      commit(i == 3);
    end
    staged.push_back(8'h00);
    commit(1'b0);
    staged.push_back(8'hFF);
    commit(1'b0);
    staged.push_back(8'hB5);
    commit(1'b0);

    target = TargetChars;
    while (pending.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        stage_rand_stamp(1'b0);
      end else if (kind < 65) begin
        stage_rand_stamp(1'b0);
        staged[$urandom_range(0, staged.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 72) begin
        stage_rand_stamp(1'b0);
        cut = $urandom_range(1, staged.size() - 1);
        while (staged.size() > cut) void'(staged.pop_back());
      end else if (kind < 77) begin
        stage_rand_stamp(1'b0);
        repeat ($urandom_range(1, 3)) staged.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) staged.push_back(8'($urandom_range(0, 255)));
      end else begin
        stage_rand_stamp(1'b1);
      end
      commit($urandom_range(0, 24) == 0);
    end

    wait (rst_ni === 1'b1);
    while (pending.size() != 0 || char_bus.valid || expected_stamps.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run: %0d timestamps over %0d characters, %0d results checked",
             strings_done, chars_taken, results_seen);
    $display("outcomes: ok %0d, format %0d, date %0d, hour %0d, minute %0d, second %0d, leap %0d",
             status_tally[StOk], status_tally[StFormat], status_tally[StDate],
             status_tally[StHour], status_tally[StMinute], status_tally[StSecond],
             status_tally[StLeapPos]);
    if (errors == 0 && expected_stamps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_stamps.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: %0d items pending, %0d results outstanding", pending.size(),
             expected_stamps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
